// ===== src/ihex_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Intel HEX record loader.
// No dependencies; used by the loader top level and its testbench.
package ihex_pkg;

  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;

  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEN     = 3'd1,
    PH_ADDR_HI = 3'd2,
    PH_ADDR_LO = 3'd3,
    PH_TYPE    = 3'd4,
    PH_DATA    = 3'd5,
    PH_CSUM    = 3'd6,
    PH_SKIP    = 3'd7
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_TYPE   = 3'd2,
    ST_CSUM   = 3'd3,
    ST_NOEND  = 3'd4
  } status_t;

  localparam logic [BYTE_W-1:0] TYPE_DATA = 8'h00;
  localparam logic [BYTE_W-1:0] TYPE_EOF  = 8'h01;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    status_t             status;
  } result_t;

endpackage

// ===== src/intel_hex_record_loader.sv =====
`timescale 1ns / 1ps
// Intel HEX record loader: character-stream parser with code-memory write output.
// Depends on ihex_pkg.
//
// Takes one file character, or an end-of-file mark (in_tuser high), per cycle while
// in_tready is high, and parses Intel HEX records in a single registered pass; a
// result, if any, is registered into the output stage. Each data byte
// leaves at once as a code-memory write (out_tuser low); a final status (out_tuser
// high) ends the file, after which the next character starts a new one. Results
// pass through an output register backed by a skid register: in_tready drops only
// while both hold a result that the downstream side has not taken.
module intel_hex_record_loader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] write_addr, [23:16] write_data,
                                  // [26:24] load_status, [31:27] zero
  output logic        out_tuser   // [0] out_kind
);

  ihex_pkg::phase_t                  phase_r, phase_nxt;
  logic                              pend_r, pend_nxt;
  logic [3:0]                        hi_r, hi_nxt;
  logic [ihex_pkg::BYTE_W-1:0]       len_r, len_nxt;
  logic [ihex_pkg::ADDR_W-1:0]       addr_r, addr_nxt;
  logic [ihex_pkg::BYTE_W-1:0]       done_r, done_nxt;
  logic [ihex_pkg::BYTE_W-1:0]       sum_r, sum_nxt;

  ihex_pkg::result_t                 head_r, skid_r, res;
  logic                              head_v_r, skid_v_r, res_v;

  logic                              accept, pop, push;
  logic                              hex_ok;
  logic [3:0]                        nib;
  logic [ihex_pkg::BYTE_W-1:0]       byte_val, done_inc;

  assign accept   = in_tvalid && in_tready;
  assign pop      = head_v_r && out_tready;
  assign push     = accept && res_v;
  assign byte_val = {hi_r, nib};
  assign done_inc = done_r + 8'd1;

  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (in_tdata >= "0" && in_tdata <= "9") begin
      nib = 4'(in_tdata - "0");
    end else if (in_tdata >= "a" && in_tdata <= "f") begin
      nib = 4'(in_tdata - "a" + 8'd10);
    end else if (in_tdata >= "A" && in_tdata <= "F") begin
      nib = 4'(in_tdata - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // next parse state and result for the current character
  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    hi_nxt     = hi_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    done_nxt   = done_r;
    sum_nxt    = sum_r;
    res_v      = 1'b0;
    res.kind   = 1'b1;
    res.addr   = '0;
    res.data   = '0;
    res.status = ihex_pkg::ST_OK;

    if (in_tuser) begin
      res_v      = 1'b1;
      res.status = (phase_r == ihex_pkg::PH_START) ? ihex_pkg::ST_FORMAT
                                                    : ihex_pkg::ST_NOEND;
    end else if (phase_r == ihex_pkg::PH_START) begin
      if (in_tdata != ihex_pkg::CHAR_COLON) begin
        res_v      = 1'b1;
        res.status = ihex_pkg::ST_FORMAT;
      end else begin
        phase_nxt = ihex_pkg::PH_LEN;
      end
    end else if (phase_r == ihex_pkg::PH_SKIP) begin
      if (in_tdata == ihex_pkg::CHAR_COLON) begin
        phase_nxt = ihex_pkg::PH_LEN;
      end
    end else if (!hex_ok) begin
      res_v      = 1'b1;
      res.status = ihex_pkg::ST_FORMAT;
    end else if (!pend_r) begin
      hi_nxt   = nib;
      pend_nxt = 1'b1;
    end else begin
      pend_nxt = 1'b0;
      sum_nxt  = sum_r + byte_val;
      unique case (phase_r)
        ihex_pkg::PH_LEN: begin
          len_nxt   = byte_val;
          phase_nxt = ihex_pkg::PH_ADDR_HI;
        end
        ihex_pkg::PH_ADDR_HI: begin
          addr_nxt  = {byte_val, 8'd0};
          phase_nxt = ihex_pkg::PH_ADDR_LO;
        end
        ihex_pkg::PH_ADDR_LO: begin
          addr_nxt  = {addr_r[15:8], byte_val};
          phase_nxt = ihex_pkg::PH_TYPE;
        end
        ihex_pkg::PH_TYPE: begin
          if (byte_val == ihex_pkg::TYPE_EOF) begin
            res_v      = 1'b1;
            res.status = ihex_pkg::ST_OK;
          end else if (byte_val != ihex_pkg::TYPE_DATA) begin
            res_v      = 1'b1;
            res.status = ihex_pkg::ST_TYPE;
          end else begin
            phase_nxt = (len_r == 8'd0) ? ihex_pkg::PH_CSUM : ihex_pkg::PH_DATA;
          end
        end
        ihex_pkg::PH_DATA: begin
          res_v    = 1'b1;
          res.kind = 1'b0;
          res.addr = addr_r + {8'd0, done_r};
          res.data = byte_val;
          done_nxt = done_inc;
          if (done_inc == len_r) begin
            phase_nxt = ihex_pkg::PH_CSUM;
          end
        end
        ihex_pkg::PH_CSUM: begin
          if (sum_nxt != 8'd0) begin
            res_v      = 1'b1;
            res.status = ihex_pkg::ST_CSUM;
          end else begin
            phase_nxt = ihex_pkg::PH_SKIP;
          end
        end
        default: begin
          phase_nxt = ihex_pkg::PH_START;
        end
      endcase
    end

    // a new record clears its fields
    if (phase_nxt == ihex_pkg::PH_LEN && phase_r != ihex_pkg::PH_LEN) begin
      pend_nxt = 1'b0;
      hi_nxt   = 4'd0;
      len_nxt  = '0;
      addr_nxt = '0;
      done_nxt = '0;
      sum_nxt  = '0;
    end

    // a final status returns to the reset state
    if (res_v && res.kind) begin
      phase_nxt = ihex_pkg::PH_START;
      pend_nxt  = 1'b0;
      hi_nxt    = 4'd0;
      len_nxt   = '0;
      addr_nxt  = '0;
      done_nxt  = '0;
      sum_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ihex_pkg::PH_START;
      pend_r  <= 1'b0;
      hi_r    <= 4'd0;
      len_r   <= '0;
      addr_r  <= '0;
      done_r  <= '0;
      sum_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      hi_r    <= hi_nxt;
      len_r   <= len_nxt;
      addr_r  <= addr_nxt;
      done_r  <= done_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        head_r   <= skid_r;
        skid_v_r <= push;
        if (push) begin
          skid_r <= res;
        end
      end else begin
        head_v_r <= push;
        if (push) begin
          head_r <= res;
        end
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_v_r <= 1'b1;
        head_r   <= res;
      end else begin
        skid_v_r <= 1'b1;
        skid_r   <= res;
      end
    end
  end

  assign in_tready  = !skid_v_r;
  assign out_tvalid = head_v_r;
  assign out_tuser  = head_r.kind;
  assign out_tdata  = {5'd0, head_r.status, head_r.data, head_r.addr};

endmodule

// ===== src/ihex_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the Intel HEX record loader, with its bind statement.
// Depends on intel_hex_record_loader.
module ihex_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result transfer changed");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:24] == 8'd0)
    else $error("write result carries a status");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[23:0] == 24'd0 && out_tdata[31:27] == 5'd0
      && (out_tdata[26:24] == 3'd0 || out_tdata[26:24] == 3'd1 || out_tdata[26:24] == 3'd2
          || out_tdata[26:24] == 3'd3 || out_tdata[26:24] == 3'd4))
    else $error("malformed status result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result channel not empty after reset");

endmodule

bind intel_hex_record_loader ihex_checker u_ihex_checker (.*);

// ===== tb/sv/intel_hex_record_loader_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for intel_hex_record_loader: directed and random HEX character
// streams with random idling on both stream sides. Depends on ihex_pkg and the loader RTL.
module intel_hex_record_loader_test;

  typedef logic [7:0] char_q_t [$];

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  intel_hex_record_loader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // loader state as predicted
  ihex_pkg::phase_t ld_phase    = ihex_pkg::PH_START;
  logic             nib_pending = 1'b0;
  logic [3:0]       nib_hi      = '0;
  logic [7:0]       rec_len     = '0;
  logic [15:0]      rec_addr    = '0;
  logic [7:0]       bytes_done  = '0;
  logic [7:0]       run_sum     = '0;

  ihex_pkg::result_t expected_results [$];

  int items_sent        = 0;
  int writes_seen       = 0;
  int statuses_seen     = 0;
  int error_count       = 0;
  int src_idle_max      = 0;
  int sink_idle_max     = 0;
  int sink_hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("intel_hex_record_loader_test: FAIL");
    $finish;
  end

  function automatic int hex_digit(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch - "0";
    if (ch >= "a" && ch <= "f") return ch - "a" + 10;
    if (ch >= "A" && ch <= "F") return ch - "A" + 10;
    return -1;
  endfunction

  function automatic void open_record();
    ld_phase    = ihex_pkg::PH_LEN;
    nib_pending = 1'b0;
    nib_hi      = '0;
    rec_len     = '0;
    rec_addr    = '0;
    bytes_done  = '0;
    run_sum     = '0;
  endfunction

  function automatic void push_status(input ihex_pkg::status_t st);
    ihex_pkg::result_t r;
    r.kind   = 1'b1;
    r.addr   = '0;
    r.data   = '0;
    r.status = st;
    expected_results.push_back(r);
    open_record();
    ld_phase = ihex_pkg::PH_START;
  endfunction

  function automatic void parse_char(input logic eof, input logic [7:0] ch);
    int                digit;
    logic [7:0]        value;
    ihex_pkg::result_t wr;
    if (eof) begin
      if (ld_phase == ihex_pkg::PH_START) push_status(ihex_pkg::ST_FORMAT);
      else push_status(ihex_pkg::ST_NOEND);
      return;
    end
    if (ld_phase == ihex_pkg::PH_START) begin
      if (ch != ihex_pkg::CHAR_COLON) push_status(ihex_pkg::ST_FORMAT);
      else open_record();
      return;
    end
    if (ld_phase == ihex_pkg::PH_SKIP) begin
      if (ch == ihex_pkg::CHAR_COLON) open_record();
      return;
    end
    digit = hex_digit(ch);
    if (digit < 0) begin
      push_status(ihex_pkg::ST_FORMAT);
      return;
    end
    if (!nib_pending) begin
      nib_hi      = digit[3:0];
      nib_pending = 1'b1;
      return;
    end
    nib_pending = 1'b0;
    value       = {nib_hi, digit[3:0]};
    nib_hi      = '0;
    case (ld_phase)
      ihex_pkg::PH_LEN: begin
        rec_len  = value;
        run_sum  = run_sum + value;
        ld_phase = ihex_pkg::PH_ADDR_HI;
      end
      ihex_pkg::PH_ADDR_HI: begin
        rec_addr = {value, 8'h00};
        run_sum  = run_sum + value;
        ld_phase = ihex_pkg::PH_ADDR_LO;
      end
      ihex_pkg::PH_ADDR_LO: begin
        rec_addr[7:0] = value;
        run_sum       = run_sum + value;
        ld_phase      = ihex_pkg::PH_TYPE;
      end
      ihex_pkg::PH_TYPE: begin
        if (value == ihex_pkg::TYPE_EOF) begin
          push_status(ihex_pkg::ST_OK);
        end else if (value != ihex_pkg::TYPE_DATA) begin
          push_status(ihex_pkg::ST_TYPE);
        end else begin
          run_sum = run_sum + value;
          if (rec_len == 8'h00) ld_phase = ihex_pkg::PH_CSUM;
          else ld_phase = ihex_pkg::PH_DATA;
        end
      end
      ihex_pkg::PH_DATA: begin
        wr.kind   = 1'b0;
        wr.addr   = rec_addr + 16'(bytes_done);
        wr.data   = value;
        wr.status = ihex_pkg::ST_OK;
        expected_results.push_back(wr);
        run_sum    = run_sum + value;
        bytes_done = bytes_done + 8'd1;
        if (bytes_done == rec_len) ld_phase = ihex_pkg::PH_CSUM;
      end
      ihex_pkg::PH_CSUM: begin
        if (8'(value + run_sum) != 8'h00) push_status(ihex_pkg::ST_CSUM);
        else ld_phase = ihex_pkg::PH_SKIP;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + nib;
    if ($urandom_range(0, 1) == 1) return "a" + nib - 8'd10;
    return "A" + nib - 8'd10;
  endfunction

  function automatic void push_hex(ref char_q_t q, input logic [7:0] b);
    q.push_back(hex_char(b[7:4]));
    q.push_back(hex_char(b[3:0]));
  endfunction

  function automatic char_q_t random_bytes(input int n);
    char_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CHAR_COLON);
    return c;
  endfunction

  // append ':' and the record's hex pairs; data records get their checksum
  function automatic void build_record(ref char_q_t q, input logic [7:0] len_field,
                                       input logic [15:0] addr, input logic [7:0] rtype,
                                       input char_q_t payload, input bit bad_sum);
    logic [7:0] sum;
    sum = len_field + addr[15:8] + addr[7:0] + rtype;
    q.push_back(ihex_pkg::CHAR_COLON);
    push_hex(q, len_field);
    push_hex(q, addr[15:8]);
    push_hex(q, addr[7:0]);
    push_hex(q, rtype);
    if (rtype != ihex_pkg::TYPE_DATA) return;
    foreach (payload[i]) begin
      push_hex(q, payload[i]);
      sum = sum + payload[i];
    end
    sum = 8'h00 - sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    push_hex(q, sum);
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 11;
      2: return 3;
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  task automatic send_item(input logic eof, input logic [7:0] ch);
    int gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= eof;
    do @(posedge clk); while (!in_tready);
    parse_char(eof, ch);
    items_sent++;
  endtask

  task automatic send_chars(input char_q_t q);
    foreach (q[i]) send_item(1'b0, q[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // downstream side: stall after each transfer, or hold off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_request > 0) begin
        stall_left        = sink_hold_request;
        sink_hold_request = 0;
      end else if (out_tvalid && out_tready) begin
        stall_left = $urandom_range(0, sink_idle_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_tready <= rst_n && (stall_left == 0);
    end
  end

  initial begin : result_checker
    ihex_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected transfer: kind %0d tdata %h", out_tuser, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.kind || out_tdata[15:0] !== want.addr ||
              out_tdata[23:16] !== want.data || out_tdata[26:24] !== want.status) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: expected kind %0d addr %h data %h status %0d, got %0d %h %h %0d",
                       want.kind, want.addr, want.data, want.status,
                       out_tuser, out_tdata[15:0], out_tdata[23:16], out_tdata[26:24]);
          end else if (want.kind) begin
            statuses_seen++;
          end else begin
            writes_seen++;
          end
        end
      end
    end
  end

  task automatic test_bad_openings();
    src_idle_max  = 0;
    sink_idle_max = 0;
    send_item(1'b0, "A");
    send_item(1'b1, 8'hFF);
    send_item(1'b0, ihex_pkg::CHAR_COLON);
    send_item(1'b0, "G");
    send_item(1'b0, ihex_pkg::CHAR_COLON);
    send_item(1'b0, "0");
    send_item(1'b1, 8'h00);
    wait_drained();
  endtask

  task automatic test_record_types();
    char_q_t q;
    char_q_t none;
    src_idle_max  = 11;
    sink_idle_max = 11;
    build_record(q, 8'h00, 16'h0000, 8'h02, none, 1'b0);
    build_record(q, 8'hFF, 16'hFFFF, 8'hFF, none, 1'b0);
    build_record(q, 8'h00, 16'h0000, ihex_pkg::TYPE_EOF, none, 1'b0);
    q.push_back("F");
    send_chars(q);
    wait_drained();
  endtask

  task automatic test_zero_length_and_skip();
    char_q_t q;
    char_q_t none;
    src_idle_max  = 0;
    sink_idle_max = 11;
    build_record(q, 8'h00, 16'h0000, ihex_pkg::TYPE_DATA, none, 1'b0);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    q.push_back("z");
    build_record(q, 8'h00, 16'h0000, ihex_pkg::TYPE_EOF, none, 1'b0);
    send_chars(q);
    wait_drained();
  endtask

  task automatic test_checksum_and_wrap();
    char_q_t q;
    char_q_t payload;
    src_idle_max  = 11;
    sink_idle_max = 0;
    payload = '{8'h00, 8'hFF};
    build_record(q, 8'h02, 16'hFFFF, ihex_pkg::TYPE_DATA, payload, 1'b1);
    send_chars(q);
    wait_drained();
  endtask

  // full-length record against a long downstream hold-off: fill up and stall the input
  task automatic test_backpressure();
    char_q_t q;
    char_q_t none;
    src_idle_max      = 0;
    sink_idle_max     = 0;
    sink_hold_request = 300;
    build_record(q, 8'hFF, 16'hFF80, ihex_pkg::TYPE_DATA, random_bytes(255), 1'b0);
    build_record(q, 8'h00, 16'h0000, ihex_pkg::TYPE_EOF, none, 1'b0);
    send_chars(q);
    wait_drained();
  endtask

  task automatic test_random_files();
    char_q_t    q;
    char_q_t    none;
    int         target;
    int         n_len;
    int         pos;
    logic [15:0] addr;
    target = items_sent + 1100;
    while (items_sent < target) begin
      q.delete();
      src_idle_max  = pick_idle();
      sink_idle_max = pick_idle();
      if ($urandom_range(0, 9) == 0) q.push_back(filler_byte());
      for (int r = $urandom_range(1, 4); r > 0; r--) begin
        if ($urandom_range(0, 49) == 0) n_len = $urandom_range(17, 255);
        else n_len = $urandom_range(0, 16);
        if ($urandom_range(0, 7) == 0) addr = 16'hFFFF - 16'($urandom_range(0, 8));
        else addr = 16'($urandom_range(0, 65535));
        build_record(q, 8'(n_len), addr, ihex_pkg::TYPE_DATA, random_bytes(n_len),
                     $urandom_range(0, 19) == 0);
        for (int j = $urandom_range(0, 3); j > 0; j--) q.push_back(filler_byte());
      end
      case ($urandom_range(0, 9))
        6: build_record(q, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        8'($urandom_range(2, 255)), none, 1'b0);
        7: ;
        8: begin
          build_record(q, 8'h00, 16'h0000, ihex_pkg::TYPE_EOF, none, 1'b0);
          pos    = $urandom_range(1, q.size() - 1);
          q[pos] = non_hex_byte();
        end
        9: begin
          pos = $urandom_range(1, q.size() - 1);
          while (q.size() > pos) void'(q.pop_back());
        end
        default: build_record(q, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                              ihex_pkg::TYPE_EOF, none, 1'b0);
      endcase
      send_chars(q);
      if (ld_phase != ihex_pkg::PH_START || $urandom_range(0, 19) == 0)
        send_item(1'b1, 8'($urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_openings();
    test_record_types();
    test_zero_length_and_skip();
    test_checksum_and_wrap();
    test_backpressure();
    test_random_files();
    repeat (10) @(posedge clk);
    $display("Run covered %0d character and end-of-file transfers into the loader,",
             items_sent);
    $display("with %0d code writes and %0d load statuses checked and %0d errors.",
             writes_seen, statuses_seen, error_count);
    if (error_count == 0) begin
      $display("intel_hex_record_loader_test: PASS");
    end else begin
      $display("intel_hex_record_loader_test: FAIL");
    end
    $finish;
  end

endmodule
